// File: design/bft_pkg.sv
// Shared types and codes of the blob frame tracker.
`default_nettype none
package bft_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2,
    ST_RD,
    ST_DX,
    ST_DY,
    ST_CMP,
    ST_HUNT,
    ST_UPRD,
    ST_UPOUT,
    ST_OUT
  } state_t;

  localparam logic [1:0] EV_DOWN  = 2'd0;
  localparam logic [1:0] EV_MOVE  = 2'd1;
  localparam logic [1:0] EV_UP    = 2'd2;
  localparam logic [1:0] EV_FRAME = 2'd3;

  // register index as decoded from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_ORIGIN = 1'b1;

  localparam logic [9:0] RADIUS_RST = 10'd20;

endpackage
`default_nettype wire

// File: design/blob_frame_tracker.sv
// Top level of the blob frame tracker: sequencer, blob store, hand pool, APB registers.
`default_nettype none
// Blob frame tracker. Blob beats of one frame arrive on in_*; each blob with a non-zero
// area id is matched, while the current bank has room, against the untracked blobs of
// the previous frame (same area, squared centre distance below match_radius squared,
// first in store order) and reported as MOVE with the inherited hand id, or as DOWN with
// a fresh id from a round-robin hunt over the hand pool; with the bank full it is reported
// as DOWN with overflow set and hand id 0, unmatched and unstored. An end-of-frame beat
// reports UP for every unmatched old blob, then a frame marker with last set, and swaps
// the two blob banks. One item is handled at a time and in_stall is high meanwhile.
// A blob first squares the radius, then per stored previous blob skips it if tracked,
// reads it and moves on if its area differs, or checks its distance (one shared 10x10
// multiplier squares dx, then dy); on a miss it hunts an id; the result beat then holds
// until taken. A blob outside any area is taken and dropped without raising in_stall.
// End of frame reports each untracked previous blob, then the marker. Both banks live in
// one store with a read and a write port; out_stall stretches every result.
module blob_frame_tracker #(
  parameter int MAX_BLOBS = 16,
  parameter int HAND_IDS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [9:0]  in_pos_x,
  input  wire logic [9:0]  in_pos_y,
  input  wire logic [7:0]  in_depth,
  input  wire logic [7:0]  in_area_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [3:0]       out_hand_id,
  output logic [9:0]       out_loc_x,
  output logic [9:0]       out_loc_y,
  output logic [7:0]       out_loc_z,
  output logic [9:0]       out_origin_x,
  output logic [9:0]       out_origin_y,
  output logic [7:0]       out_origin_z,
  output logic [7:0]       out_region,
  output logic             out_overflow,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bft_pkg::*;

  localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOBS + 1);
  localparam int HID_W = (HAND_IDS > 1) ? $clog2(HAND_IDS) : 1;
  localparam int MEM_D = 2 << IDX_W;

  typedef struct packed {
    logic [HID_W-1:0] hand;
    logic [7:0]       oz;
    logic [9:0]       oy;
    logic [9:0]       ox;
    logic [7:0]       area;
    logic [7:0]       z;
    logic [9:0]       y;
    logic [9:0]       x;
  } entry_t;

  // ---------------------------------------------------------------- control registers
  state_t               state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 bank_r, bank_nxt;         // bank holding the previous frame
  logic [CNT_W-1:0]     prev_cnt_r, prev_cnt_nxt;
  logic [CNT_W-1:0]     cur_cnt_r, cur_cnt_nxt;
  logic [MAX_BLOBS-1:0] tracked_r, tracked_nxt;
  logic [HAND_IDS-1:0]  inuse_r, inuse_nxt;
  logic [HID_W-1:0]     last_hand_r, last_hand_nxt;
  logic [HID_W-1:0]     nh_r, nh_nxt;
  logic [9:0]           radius_r;
  logic                 kfo_r;

  // ---------------------------------------------------------------- datapath registers
  logic [19:0] r2_r, r2_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [9:0]  bx_r, by_r;
  logic [7:0]  bz_r, barea_r;

  logic [1:0]  o_ev_r, o_ev_nxt;
  logic [3:0]  o_hand_r, o_hand_nxt;
  logic [9:0]  o_lx_r, o_lx_nxt, o_ly_r, o_ly_nxt, o_ox_r, o_ox_nxt, o_oy_r, o_oy_nxt;
  logic [7:0]  o_lz_r, o_lz_nxt, o_oz_r, o_oz_nxt, o_reg_r, o_reg_nxt;
  logic        o_ovf_r, o_ovf_nxt, o_last_r, o_last_nxt;

  // ---------------------------------------------------------------- blob store
  logic [$bits(entry_t)-1:0] store_mem [MEM_D];
  logic [$bits(entry_t)-1:0] mem_q_r;
  logic                      mem_re, mem_we;
  logic [IDX_W:0]            mem_ra, mem_wa;
  entry_t                    mem_wd, q;

  assign q = entry_t'(mem_q_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= store_mem[mem_ra];
    end
  end

  // ---------------------------------------------------------------- handshakes
  logic in_acc, out_acc, cfg_wr;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_acc   = out_valid && !out_stall;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ORIGIN) ? {31'd0, kfo_r} : {22'd0, radius_r};

  // ---------------------------------------------------------------- shared multiplier
  logic [10:0] dx_diff, dy_diff;
  logic [9:0]  dx_abs, dy_abs, mul_a, mul_b;
  logic [19:0] prod;

  assign dx_diff = {1'b0, bx_r} - {1'b0, q.x};
  assign dy_diff = {1'b0, by_r} - {1'b0, q.y};
  assign dx_abs  = dx_diff[10] ? 10'(-dx_diff) : dx_diff[9:0];
  assign dy_abs  = dy_diff[10] ? 10'(-dy_diff) : dy_diff[9:0];

  always_comb begin
    unique case (state_r)
      ST_R2: begin
        mul_a = radius_r;
        mul_b = radius_r;
      end
      ST_DX: begin
        mul_a = dx_abs;
        mul_b = dx_abs;
      end
      ST_DY: begin
        mul_a = dy_abs;
        mul_b = dy_abs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------- sequencer
  logic [HID_W-1:0] nh_inc;
  assign nh_inc = (nh_r == HID_W'(HAND_IDS - 1)) ? '0 : nh_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    idx_nxt       = idx_r;
    bank_nxt      = bank_r;
    prev_cnt_nxt  = prev_cnt_r;
    cur_cnt_nxt   = cur_cnt_r;
    tracked_nxt   = tracked_r;
    inuse_nxt     = inuse_r;
    last_hand_nxt = last_hand_r;
    nh_nxt        = nh_r;
    r2_nxt        = r2_r;
    acc_nxt       = acc_r;
    o_ev_nxt      = o_ev_r;
    o_hand_nxt    = o_hand_r;
    o_lx_nxt      = o_lx_r;
    o_ly_nxt      = o_ly_r;
    o_lz_nxt      = o_lz_r;
    o_ox_nxt      = o_ox_r;
    o_oy_nxt      = o_oy_r;
    o_oz_nxt      = o_oz_r;
    o_reg_nxt     = o_reg_r;
    o_ovf_nxt     = o_ovf_r;
    o_last_nxt    = o_last_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_ra        = {bank_r, idx_r[IDX_W-1:0]};
    mem_wa        = {~bank_r, cur_cnt_r[IDX_W-1:0]};
    mem_wd        = '{hand: '0, oz: bz_r, oy: by_r, ox: bx_r, area: barea_r,
                      z: bz_r, y: by_r, x: bx_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (in_action) begin
            state_nxt = ST_UPRD;
          end else if (in_area_id == '0) begin
            state_nxt = ST_IDLE;          // outside any area: dropped
          end else if (cur_cnt_r >= CNT_W'(MAX_BLOBS)) begin
            // store full: report without matching or storing
            o_ev_nxt   = EV_DOWN;
            o_hand_nxt = '0;
            o_lx_nxt   = in_pos_x;
            o_ly_nxt   = in_pos_y;
            o_lz_nxt   = in_depth;
            o_ox_nxt   = in_pos_x;
            o_oy_nxt   = in_pos_y;
            o_oz_nxt   = in_depth;
            o_reg_nxt  = in_area_id;
            o_ovf_nxt  = 1'b1;
            o_last_nxt = 1'b1;
            ret_nxt    = ST_IDLE;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_R2;
          end
        end
      end

      ST_R2: begin
        r2_nxt    = prod;
        state_nxt = ST_RD;
      end

      ST_RD: begin
        if (idx_r >= prev_cnt_r) begin
          nh_nxt    = (last_hand_r == HID_W'(HAND_IDS - 1)) ? '0 : last_hand_r + 1'b1;
          state_nxt = ST_HUNT;
        end else if (tracked_r[idx_r[IDX_W-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_DX;
        end
      end

      ST_DX: begin
        if (q.area != barea_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end else begin
          acc_nxt   = {1'b0, prod};
          state_nxt = ST_DY;
        end
      end

      ST_DY: begin
        acc_nxt   = acc_r + {1'b0, prod};
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if (acc_r < {1'b0, r2_r}) begin
          tracked_nxt[idx_r[IDX_W-1:0]] = 1'b1;
          mem_wd.hand = q.hand;
          if (kfo_r) begin
            mem_wd.ox = q.ox;
            mem_wd.oy = q.oy;
            mem_wd.oz = q.oz;
          end else begin
            mem_wd.ox = q.x;
            mem_wd.oy = q.y;
            mem_wd.oz = q.z;
          end
          mem_we      = 1'b1;
          cur_cnt_nxt = cur_cnt_r + 1'b1;
          o_ev_nxt    = EV_MOVE;
          o_hand_nxt  = 4'(mem_wd.hand);
          o_lx_nxt    = bx_r;
          o_ly_nxt    = by_r;
          o_lz_nxt    = bz_r;
          o_ox_nxt    = mem_wd.ox;
          o_oy_nxt    = mem_wd.oy;
          o_oz_nxt    = mem_wd.oz;
          o_reg_nxt   = barea_r;
          o_ovf_nxt   = 1'b0;
          o_last_nxt  = 1'b1;
          ret_nxt     = ST_IDLE;
          state_nxt   = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end
      end

      ST_HUNT: begin
        if (inuse_r[nh_r] && (nh_r != last_hand_r)) begin
          nh_nxt = nh_inc;
        end else begin
          inuse_nxt[nh_r] = 1'b1;
          last_hand_nxt   = nh_r;
          mem_wd.hand     = nh_r;
          mem_we          = 1'b1;
          cur_cnt_nxt     = cur_cnt_r + 1'b1;
          o_ev_nxt        = EV_DOWN;
          o_hand_nxt      = 4'(nh_r);
          o_lx_nxt        = bx_r;
          o_ly_nxt        = by_r;
          o_lz_nxt        = bz_r;
          o_ox_nxt        = bx_r;
          o_oy_nxt        = by_r;
          o_oz_nxt        = bz_r;
          o_reg_nxt       = barea_r;
          o_ovf_nxt       = 1'b0;
          o_last_nxt      = 1'b1;
          ret_nxt         = ST_IDLE;
          state_nxt       = ST_OUT;
        end
      end

      ST_UPRD: begin
        if (idx_r >= prev_cnt_r) begin
          // frame marker, then swap banks
          o_ev_nxt     = EV_FRAME;
          o_hand_nxt   = '0;
          o_lx_nxt     = '0;
          o_ly_nxt     = '0;
          o_lz_nxt     = '0;
          o_ox_nxt     = '0;
          o_oy_nxt     = '0;
          o_oz_nxt     = '0;
          o_reg_nxt    = '0;
          o_ovf_nxt    = 1'b0;
          o_last_nxt   = 1'b1;
          bank_nxt     = ~bank_r;
          prev_cnt_nxt = cur_cnt_r;
          cur_cnt_nxt  = '0;
          tracked_nxt  = '0;
          ret_nxt      = ST_IDLE;
          state_nxt    = ST_OUT;
        end else if (tracked_r[idx_r[IDX_W-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_UPOUT;
        end
      end

      ST_UPOUT: begin
        inuse_nxt[q.hand] = 1'b0;
        o_ev_nxt   = EV_UP;
        o_hand_nxt = 4'(q.hand);
        o_lx_nxt   = q.x;
        o_ly_nxt   = q.y;
        o_lz_nxt   = q.z;
        o_ox_nxt   = q.ox;
        o_oy_nxt   = q.oy;
        o_oz_nxt   = q.oz;
        o_reg_nxt  = q.area;
        o_ovf_nxt  = 1'b0;
        o_last_nxt = 1'b0;
        idx_nxt    = idx_r + 1'b1;
        ret_nxt    = ST_UPRD;
        state_nxt  = ST_OUT;
      end

      ST_OUT: begin
        if (out_acc) begin
          state_nxt = ret_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      idx_r       <= '0;
      bank_r      <= 1'b0;
      prev_cnt_r  <= '0;
      cur_cnt_r   <= '0;
      tracked_r   <= '0;
      inuse_r     <= '0;
      last_hand_r <= HID_W'(HAND_IDS - 1);
      radius_r    <= RADIUS_RST;
      kfo_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      idx_r       <= idx_nxt;
      bank_r      <= bank_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      tracked_r   <= tracked_nxt;
      inuse_r     <= inuse_nxt;
      last_hand_r <= last_hand_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_RADIUS) begin
          radius_r <= cfg_pwdata[9:0];
        end else begin
          kfo_r <= cfg_pwdata[0];
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    nh_r     <= nh_nxt;
    r2_r     <= r2_nxt;
    acc_r    <= acc_nxt;
    o_ev_r   <= o_ev_nxt;
    o_hand_r <= o_hand_nxt;
    o_lx_r   <= o_lx_nxt;
    o_ly_r   <= o_ly_nxt;
    o_lz_r   <= o_lz_nxt;
    o_ox_r   <= o_ox_nxt;
    o_oy_r   <= o_oy_nxt;
    o_oz_r   <= o_oz_nxt;
    o_reg_r  <= o_reg_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
    if (in_acc) begin
      bx_r    <= in_pos_x;
      by_r    <= in_pos_y;
      bz_r    <= in_depth;
      barea_r <= in_area_id;
    end
  end

  assign out_event_res = o_ev_r;
  assign out_hand_id   = o_hand_r;
  assign out_loc_x     = o_lx_r;
  assign out_loc_y     = o_ly_r;
  assign out_loc_z     = o_lz_r;
  assign out_origin_x  = o_ox_r;
  assign out_origin_y  = o_oy_r;
  assign out_origin_z  = o_oz_r;
  assign out_region    = o_reg_r;
  assign out_overflow  = o_ovf_r;
  assign out_last      = o_last_r;

  // ---------------------------------------------------------------- checks
  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_cnt_r <= CNT_W'(MAX_BLOBS))
    else $error("current blob count past store size");

  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_FRAME) |-> out_last && !out_overflow)
    else $error("frame marker without last");

  a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action |=> in_stall)
    else $error("end of frame not processed");

  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (out_event_res == EV_FRAME) |-> (cur_cnt_r == '0) && (tracked_r == '0))
    else $error("bank swap incomplete at frame marker");

endmodule
`default_nettype wire

// File: test/bft_checker.sv
// Checker: watches both channels of the blob frame tracker, predicts events and compares.
`timescale 1ns / 1ps
module bft_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_action,
  input  wire logic [9:0]  in_pos_x,
  input  wire logic [9:0]  in_pos_y,
  input  wire logic [7:0]  in_depth,
  input  wire logic [7:0]  in_area_id,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_event_res,
  input  wire logic [3:0]  out_hand_id,
  input  wire logic [9:0]  out_loc_x,
  input  wire logic [9:0]  out_loc_y,
  input  wire logic [7:0]  out_loc_z,
  input  wire logic [9:0]  out_origin_x,
  input  wire logic [9:0]  out_origin_y,
  input  wire logic [7:0]  out_origin_z,
  input  wire logic [7:0]  out_region,
  input  wire logic        out_overflow,
  input  wire logic        out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending_events
);
  import bft_pkg::*;

  typedef struct packed {
    logic [1:0] ev;
    logic [3:0] hand;
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] z;
    logic [9:0] ox;
    logic [9:0] oy;
    logic [7:0] oz;
    logic [7:0] area;
    logic       ovf;
    logic       last;
  } hand_event_t;

  typedef struct {
    logic [9:0] x, y, ox, oy;
    logic [7:0] z, oz, area;
    logic [3:0] hand;
  } blob_rec_t;

  blob_rec_t   old_blobs[16];
  blob_rec_t   new_blobs[16];
  logic        old_tracked[16];
  logic        hand_busy[16];
  int          old_n, new_n;
  logic [3:0]  last_hand;
  logic [9:0]  radius;
  logic        keep_origin;
  hand_event_t event_q[$];

  function automatic hand_event_t mk_event(logic [1:0] ev, blob_rec_t b, logic ovf, logic lst);
    hand_event_t e;
    e = '{ev, b.hand, b.x, b.y, b.z, b.ox, b.oy, b.oz, b.area, ovf, lst};
    return e;
  endfunction

  // append one expected beat at the tail
  task automatic add_expected(hand_event_t e);
    event_q.insert(event_q.size(), e);
  endtask

  task automatic track_beat(logic act, logic [9:0] px, logic [9:0] py, logic [7:0] dz,
                            logic [7:0] ar);
    blob_rec_t  b;
    blob_rec_t  zb;
    bit         found;
    int         dx, dy;
    longint     d2, r2;
    logic [3:0] nh;
    if (act) begin
      for (int i = 0; i < old_n; i++)
        if (!old_tracked[i]) begin
          hand_busy[old_blobs[i].hand] = 1'b0;
          add_expected(mk_event(EV_UP, old_blobs[i], 1'b0, 1'b0));
        end
      zb = '{default: '0};
      add_expected(mk_event(EV_FRAME, zb, 1'b0, 1'b1));
      old_blobs = new_blobs;
      old_n = new_n;
      foreach (old_tracked[i]) old_tracked[i] = 1'b0;
      new_n = 0;
      return;
    end
    b = '{x: px, y: py, z: dz, area: ar, ox: px, oy: py, oz: dz, hand: 4'd0};
    if (ar == 8'd0) return;
    if (new_n >= 16) begin
      add_expected(mk_event(EV_DOWN, b, 1'b1, 1'b1));
      return;
    end
    found = 0;
    r2 = longint'(radius) * longint'(radius);
    for (int i = 0; i < old_n && !found; i++) begin
      if (old_tracked[i] || old_blobs[i].area != ar) continue;
      dx = int'(px) - int'(old_blobs[i].x);
      dy = int'(py) - int'(old_blobs[i].y);
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      if (d2 < r2) begin
        old_tracked[i] = 1'b1;
        b.hand = old_blobs[i].hand;
        if (keep_origin) begin
          b.ox = old_blobs[i].ox; b.oy = old_blobs[i].oy; b.oz = old_blobs[i].oz;
        end else begin
          b.ox = old_blobs[i].x; b.oy = old_blobs[i].y; b.oz = old_blobs[i].z;
        end
        found = 1;
      end
    end
    if (!found) begin
      nh = last_hand + 4'd1;
      while (hand_busy[nh] && nh != last_hand) nh = nh + 4'd1;
      hand_busy[nh] = 1'b1;
      last_hand = nh;
      b.hand = nh;
    end
    new_blobs[new_n] = b;
    new_n++;
    add_expected(mk_event(found ? EV_MOVE : EV_DOWN, b, 1'b0, 1'b1));
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  hand_event_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      old_n = 0; new_n = 0; last_hand = 4'd15;
      radius = RADIUS_RST; keep_origin = 1'b0;
      foreach (hand_busy[i]) begin hand_busy[i] = 1'b0; old_tracked[i] = 1'b0; end
      event_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_RADIUS) radius = cfg_pwdata[9:0];
        else keep_origin = cfg_pwdata[0];
      end
      if (out_valid && !out_stall) begin
        got = '{out_event_res, out_hand_id, out_loc_x, out_loc_y, out_loc_z, out_origin_x,
                out_origin_y, out_origin_z, out_region, out_overflow, out_last};
        if (event_q.size() == 0) report_mismatch("result beat with nothing expected");
        else begin
          want = event_q.pop_front();
          if (got.ev != want.ev) report_mismatch($sformatf("event %0d/%0d", got.ev, want.ev));
          if (got.hand != want.hand) report_mismatch($sformatf("hand %0d/%0d", got.hand, want.hand));
          if (got.x != want.x || got.y != want.y || got.z != want.z)
            report_mismatch("location");
          if (got.ox != want.ox || got.oy != want.oy || got.oz != want.oz)
            report_mismatch("origin");
          if (got.area != want.area) report_mismatch("region");
          if (got.ovf != want.ovf) report_mismatch("overflow");
          if (got.last != want.last) report_mismatch("last");
        end
      end
      if (in_valid && !in_stall)
        track_beat(in_action, in_pos_x, in_pos_y, in_depth, in_area_id);
    end
    pending_events = event_q.size();
  end
endmodule

// File: test/tb_blob_frame_tracker.sv
// Testbench top: drives blob and end-of-frame beats and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_blob_frame_tracker;
  import bft_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_action;
  logic [9:0]  in_pos_x, in_pos_y;
  logic [7:0]  in_depth, in_area_id;
  logic        out_valid, out_stall;
  logic [1:0]  out_event_res;
  logic [3:0]  out_hand_id;
  logic [9:0]  out_loc_x, out_loc_y, out_origin_x, out_origin_y;
  logic [7:0]  out_loc_z, out_origin_z, out_region;
  logic        out_overflow, out_last;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_events;

  blob_frame_tracker DUT (.*);
  bft_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // result side back-pressure, with calm stretches of no stall at all
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(60, 1);
      repeat (n) @(negedge clk);
      if ($urandom_range(3) != 0) begin
        out_stall = 1'b1;
        repeat (gap_len() + 1) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // send one beat; returns at the falling edge after it is taken
  task automatic send_beat(logic act, logic [9:0] px, logic [9:0] py, logic [7:0] dz,
                           logic [7:0] ar);
    repeat (gap_len()) @(negedge clk);
    in_valid = 1'b1; in_action = act;
    in_pos_x = px; in_pos_y = py; in_depth = dz; in_area_id = ar;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  // wait until every expected beat has been seen, then let the block settle
  task automatic drain();
    while (pending_events != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // a frame of blobs drifting around a few anchors, so most beats find a match
  logic [9:0] anchor_x[6], anchor_y[6];
  logic [7:0] anchor_a[6];

  task automatic random_frame(int nblobs);
    int k, j;
    logic [9:0] px, py;
    for (k = 0; k < nblobs; k++) begin
      j = $urandom_range(5);
      if ($urandom_range(9) == 0)
        send_beat(1'b0, 10'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
      else if ($urandom_range(19) == 0)
        send_beat(1'b0, 10'($urandom), 10'($urandom), 8'($urandom), 8'd0);
      else begin
        px = anchor_x[j] + 10'($urandom_range(30)) - 10'd15;
        py = anchor_y[j] + 10'($urandom_range(30)) - 10'd15;
        send_beat(1'b0, px, py, 8'($urandom), anchor_a[j]);
        anchor_x[j] = px; anchor_y[j] = py;
      end
    end
    send_beat(1'b1, 10'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int sent;
    rst_n = 1'b0; in_valid = 1'b0; in_action = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_depth = '0; in_area_id = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, area zero, matches, end of frame at reset radius
    send_beat(1'b0, 10'd0, 10'd0, 8'd0, 8'd1);
    send_beat(1'b0, 10'd1023, 10'd1023, 8'd255, 8'd255);
    send_beat(1'b0, 10'd500, 10'd500, 8'd7, 8'd0);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    send_beat(1'b0, 10'd10, 10'd10, 8'd3, 8'd1);
    send_beat(1'b0, 10'd1013, 10'd1013, 8'd9, 8'd255);
    send_beat(1'b1, 10'd1023, 10'd1023, 8'd255, 8'd255);
    drain();
    write_reg(REG_ORIGIN, 32'd1);
    write_reg(REG_RADIUS, 32'd1023);
    // store full: 17 blobs in one frame; all ids taken
    for (int k = 0; k < 17; k++) send_beat(1'b0, 10'(k * 7), 10'(k * 3), 8'(k), 8'd2);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    send_beat(1'b0, 10'd5, 10'd5, 8'd1, 8'd2);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    drain();
    write_reg(REG_RADIUS, 32'd0);
    send_beat(1'b0, 10'd5, 10'd5, 8'd1, 8'd2);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    send_beat(1'b0, 10'd5, 10'd5, 8'd1, 8'd2);
    send_beat(1'b1, 10'd0, 10'd0, 8'd0, 8'd0);
    drain();

    // random: phases with differing register settings
    sent = 0;
    for (int ph = 0; sent < 280; ph++) begin
      write_reg(REG_RADIUS, (ph % 4 == 0) ? 32'd1023 : (ph % 4 == 1) ? 32'd1 :
                $urandom_range(60, 5));
      write_reg(REG_ORIGIN, $urandom);
      for (int j = 0; j < 6; j++) begin
        anchor_x[j] = 10'($urandom); anchor_y[j] = 10'($urandom);
        anchor_a[j] = 8'($urandom_range(3, 1));
      end
      for (int f = 0; f < 6; f++) begin
        int nb;
        nb = ($urandom_range(15) == 0) ? 18 : $urandom_range(7);
        random_frame(nb);
        sent += nb + 1;
      end
      drain();
    end

    drain();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
